>>> rtl/spem_pkg.sv
// Package: widths, kinds, states and the infinity code for the shortest-path edge marker
package spem_pkg;
    localparam int MAX_NODES   = 256;
    localparam int MAX_EDGES   = 1024;
    localparam int WEIGHT_BITS = 16;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int EDGE_W      = $clog2(MAX_EDGES);
    localparam int CNT_W       = EDGE_W + 1;
    localparam int NCFG_W      = 9;
    localparam int DIST_W      = 25;
    localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_EDGE,
        ST_RELAX,
        ST_NEXT_SRC,
        ST_Q_EDGE,
        ST_Q_D1,
        ST_Q_D2,
        ST_Q_EVAL,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [NODE_W-1:0]      a;
        logic [NODE_W-1:0]      b;
        logic [WEIGHT_BITS-1:0] w;
    } edge_t;
endpackage

>>> rtl/spem_if.sv
// Interfaces: input word and result word channels
interface spem_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] node_a;
    logic [7:0] node_b;
    logic [15:0] weight;
    logic [9:0] edge_index;
    modport source (output valid, kind, node_a, node_b, weight, edge_index, input ready);
    modport sink (input valid, kind, node_a, node_b, weight, edge_index, output ready);
endinterface

interface spem_out_if;
    logic       valid;
    logic       ready;
    logic [9:0] answer_index;
    logic       on_shortest_path;
    logic       bad_index;
    modport source (output valid, answer_index, on_shortest_path, bad_index, input ready);
    modport sink (input valid, answer_index, on_shortest_path, bad_index, output ready);
endinterface

>>> rtl/shortest_path_edge_marker_core.sv
// Top level: edge store, array-scan distance engine and query evaluation
// Load and clear words are accepted back to back. Query with distances ready: the result
// is valid after states Q_EDGE, Q_D1, Q_D2 and Q_EVAL; the next word is taken the cycle
// after the result leaves. First query after a change, per source: init sweep of all 256
// nodes, per settled node a node scan and edge sweep, a last scan and a switch state.
// Reset (rst_n low, asynchronous): edge count zero, node_count 2, distances not ready.
module shortest_path_edge_marker_core (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [8:0] cfg_wdata,
    spem_in_if.sink    in_ch,
    spem_out_if.source out_ch
);
    import spem_pkg::*;

    edge_t             edge_mem [MAX_EDGES];
    logic [DIST_W-1:0] ds_mem   [MAX_NODES];
    logic [DIST_W-1:0] de_mem   [MAX_NODES];
    logic              settled_mem [MAX_NODES];

    state_t state_reg, state_next;
    logic [CNT_W-1:0]  total_reg;
    logic [NCFG_W-1:0] ncfg_reg;
    logic              ready_reg;
    logic              src_reg;
    logic [NCFG_W-1:0] i_reg;
    logic [NODE_W-1:0] best_reg;
    logic              found_reg;
    logic [DIST_W-1:0] bdist_reg;
    logic [CNT_W-1:0]  k_reg;
    logic [EDGE_W-1:0] qidx_reg;
    logic [DIST_W-1:0] tot_reg;
    logic [DIST_W-1:0] su_reg, sv_reg, eu_reg, ev_reg;
    logic              ov_reg, ob_reg;
    logic [9:0]        oidx_reg;

    // memory ports
    logic              e_we;
    logic [EDGE_W-1:0] e_raddr;
    edge_t             e_rdata;
    logic              d_we;
    logic [NODE_W-1:0] d_waddr, d_ra1, d_ra2;
    logic [DIST_W-1:0] d_wdata;
    logic [DIST_W-1:0] ds_r1, ds_r2, de_r1, de_r2;
    logic              s_we;
    logic [NODE_W-1:0] s_waddr;
    logic              s_wdata;
    logic              settled_rd;

    logic [NCFG_W-1:0] n_use;
    logic [NODE_W-1:0] tgt;
    logic [DIST_W-1:0] cur1, cur2;
    logic              in_fire, out_fire;
    logic [DIST_W:0]   nd;
    logic              e_ok;

    assign n_use = (ncfg_reg < NCFG_W'(2)) ? NCFG_W'(2) :
                   (ncfg_reg > NCFG_W'(MAX_NODES)) ? NCFG_W'(MAX_NODES) : ncfg_reg;
    assign tgt = NODE_W'(n_use - NCFG_W'(1));
    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE) && !out_ch.valid;
    assign out_ch.valid = (state_reg == ST_OUT);
    assign out_ch.answer_index = oidx_reg;
    assign out_ch.on_shortest_path = ov_reg;
    assign out_ch.bad_index = ob_reg;
    assign cur1 = src_reg ? de_r1 : ds_r1;
    assign cur2 = src_reg ? de_r2 : ds_r2;
    assign e_ok = ({1'b0, e_rdata.a} < n_use) && ({1'b0, e_rdata.b} < n_use);

    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            edge_mem[total_reg[EDGE_W-1:0]] <= '{a: in_ch.node_a, b: in_ch.node_b,
                                                  w: in_ch.weight};
        end
        e_rdata <= edge_mem[e_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (d_we && !src_reg)
        begin
            ds_mem[d_waddr] <= d_wdata;
        end
        if (d_we && src_reg)
        begin
            de_mem[d_waddr] <= d_wdata;
        end
        ds_r1 <= ds_mem[d_ra1];
        ds_r2 <= ds_mem[d_ra2];
        de_r1 <= de_mem[d_ra1];
        de_r2 <= de_mem[d_ra2];
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            settled_mem[s_waddr] <= s_wdata;
        end
        settled_rd <= settled_mem[i_reg[NODE_W-1:0]];
    end

    always_comb
    begin
        state_next = state_reg;
        e_we    = 1'b0;
        e_raddr = k_reg[EDGE_W-1:0];
        d_we    = 1'b0;
        d_waddr = i_reg[NODE_W-1:0];
        d_wdata = DIST_INF;
        d_ra1   = i_reg[NODE_W-1:0];
        d_ra2   = i_reg[NODE_W-1:0];
        s_we    = 1'b0;
        s_waddr = i_reg[NODE_W-1:0];
        s_wdata = 1'b0;
        nd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                e_raddr = in_ch.edge_index;
                if (in_fire)
                begin
                    priority case (kind_t'(in_ch.kind))
                        KIND_LOAD:  e_we = (total_reg < CNT_W'(MAX_EDGES));
                        KIND_QUERY: state_next = ready_reg ? ST_Q_EDGE : ST_INIT;
                        default:    ;
                    endcase
                end
            end
            ST_INIT:
            begin
                d_we = 1'b1;
                s_we = 1'b1;
                d_wdata = ((!src_reg && i_reg == '0) ||
                           (src_reg && i_reg[NODE_W-1:0] == tgt)) ? '0 : DIST_INF;
                if (i_reg == NCFG_W'(MAX_NODES - 1))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (i_reg + NCFG_W'(1) >= n_use)
                begin
                    state_next = ST_SCAN_LAST;
                end
            end
            ST_SCAN_LAST:
            begin
                state_next = ST_EDGE;
            end
            ST_EDGE:
            begin
                // data for edge k_reg-1 arrives here; k_reg counts edges issued
                if (!found_reg)
                begin
                    state_next = ST_NEXT_SRC;
                end
                else if (k_reg == '0)
                begin
                    s_we = 1'b1;
                    s_waddr = best_reg;
                    s_wdata = 1'b1;
                    state_next = (total_reg == '0) ? ST_SCAN : ST_EDGE;
                end
                else
                begin
                    e_raddr = EDGE_W'(k_reg - CNT_W'(1));
                    d_ra1 = e_rdata.a;
                    d_ra2 = e_rdata.b;
                    state_next = ST_RELAX;
                end
            end
            ST_RELAX:
            begin
                if (e_ok && e_rdata.a == best_reg)
                begin
                    nd = {1'b0, bdist_reg} + (DIST_W + 1)'(e_rdata.w);
                    if (nd < {1'b0, cur2})
                    begin
                        d_we = 1'b1;
                        d_waddr = e_rdata.b;
                        d_wdata = nd[DIST_W-1:0];
                    end
                end
                else if (e_ok && e_rdata.b == best_reg)
                begin
                    nd = {1'b0, bdist_reg} + (DIST_W + 1)'(e_rdata.w);
                    if (nd < {1'b0, cur1})
                    begin
                        d_we = 1'b1;
                        d_waddr = e_rdata.a;
                        d_wdata = nd[DIST_W-1:0];
                    end
                end
                state_next = (k_reg >= total_reg) ? ST_SCAN : ST_EDGE;
            end
            ST_NEXT_SRC:
            begin
                state_next = src_reg ? ST_Q_EDGE : ST_INIT;
                e_raddr = qidx_reg;
            end
            ST_Q_EDGE:
            begin
                e_raddr = qidx_reg;
                d_ra1 = tgt;
                state_next = ST_Q_D1;
            end
            ST_Q_D1:
            begin
                e_raddr = qidx_reg;
                d_ra1 = e_rdata.a;
                d_ra2 = e_rdata.b;
                state_next = ST_Q_D2;
            end
            ST_Q_D2:
            begin
                e_raddr = qidx_reg;
                state_next = ST_Q_EVAL;
            end
            ST_Q_EVAL:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
            ncfg_reg  <= NCFG_W'(2);
            ready_reg <= 1'b0;
            src_reg   <= 1'b0;
            i_reg     <= '0;
            k_reg     <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                ncfg_reg  <= cfg_wdata;
                ready_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        qidx_reg <= in_ch.edge_index;
                        src_reg  <= 1'b0;
                        i_reg    <= '0;
                        priority case (kind_t'(in_ch.kind))
                            KIND_LOAD:
                            begin
                                if (total_reg < CNT_W'(MAX_EDGES))
                                begin
                                    total_reg <= total_reg + CNT_W'(1);
                                end
                                ready_reg <= 1'b0;
                            end
                            KIND_CLEAR:
                            begin
                                total_reg <= '0;
                                ready_reg <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_INIT:
                begin
                    if (i_reg == NCFG_W'(MAX_NODES - 1))
                    begin
                        i_reg <= '0;
                        found_reg <= 1'b0;
                    end
                    else
                    begin
                        i_reg <= i_reg + NCFG_W'(1);
                    end
                end
                ST_SCAN, ST_SCAN_LAST:
                begin
                    // compare node read last cycle (i_reg-1)
                    if (i_reg != '0 && !settled_rd &&
                        cur1 != DIST_INF && (!found_reg || cur1 < bdist_reg))
                    begin
                        found_reg <= 1'b1;
                        best_reg  <= NODE_W'(i_reg - NCFG_W'(1));
                        bdist_reg <= cur1;
                    end
                    i_reg <= i_reg + NCFG_W'(1);
                    k_reg <= '0;
                end
                ST_EDGE:
                begin
                    if (!found_reg)
                    begin
                        i_reg <= '0;
                    end
                    else if (k_reg == '0)
                    begin
                        if (total_reg == '0)
                        begin
                            i_reg <= '0;
                            found_reg <= 1'b0;
                        end
                        else
                        begin
                            k_reg <= CNT_W'(1);
                        end
                    end
                end
                ST_RELAX:
                begin
                    if (k_reg >= total_reg)
                    begin
                        i_reg <= '0;
                        found_reg <= 1'b0;
                    end
                    else
                    begin
                        k_reg <= k_reg + CNT_W'(1);
                    end
                end
                ST_NEXT_SRC:
                begin
                    i_reg <= '0;
                    if (src_reg)
                    begin
                        ready_reg <= 1'b1;
                    end
                    src_reg <= 1'b1;
                end
                ST_Q_EDGE:
                begin
                    src_reg <= 1'b0;
                end
                ST_Q_D1:
                begin
                    tot_reg <= ds_r1;
                end
                ST_Q_D2:
                begin
                    su_reg <= ds_r1;
                    sv_reg <= ds_r2;
                    eu_reg <= de_r1;
                    ev_reg <= de_r2;
                end
                ST_Q_EVAL:
                begin
                    oidx_reg <= qidx_reg;
                    ob_reg <= ({1'b0, qidx_reg} >= total_reg);
                    ov_reg <= ({1'b0, qidx_reg} < total_reg) && e_ok &&
                              tot_reg != DIST_INF &&
                              ((su_reg != DIST_INF && ev_reg != DIST_INF &&
                                ({2'b0, su_reg} + (DIST_W + 2)'(e_rdata.w) +
                                 {2'b0, ev_reg}) == {2'b0, tot_reg}) ||
                               (sv_reg != DIST_INF && eu_reg != DIST_INF &&
                                ({2'b0, sv_reg} + (DIST_W + 2)'(e_rdata.w) +
                                 {2'b0, eu_reg}) == {2'b0, tot_reg}));
                end
                default: ;
            endcase
        end
    end
endmodule

>>> verif/testbench.sv
// Testbench for the shortest-path edge marker: directed table, random graphs, predicted answers
`timescale 1ns / 1ps

module testbench;
    import spem_pkg::*;

    localparam longint FAR = 64'd9000000000000000000;

    typedef struct {
        logic [9:0] idx;
        logic       onp;
        logic       bad;
    } answer_t;

    typedef enum int { ROW_WORD, ROW_CFG } row_op_t;

    typedef struct {
        row_op_t     op;
        kind_t       kind;
        int          a;
        int          b;
        int          w;
        int          idx;
        bit          typed;
        bit          onp;
        bit          bad;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [8:0] cfg_wdata;

    spem_in_if  in_ch ();
    spem_out_if out_ch ();

    shortest_path_edge_marker_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    // predictor state
    logic [7:0]  edge_a [MAX_EDGES];
    logic [7:0]  edge_b [MAX_EDGES];
    logic [15:0] edge_w [MAX_EDGES];
    int          edge_count;
    longint      from_start [MAX_NODES];
    longint      from_end [MAX_NODES];
    bit          dist_valid;
    logic [8:0]  node_reg;

    answer_t answer_q[$];
    int      errors;
    int      burst_left;
    int      hold_req;
    int      words_sent;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int active_nodes();
        if (node_reg < 2)
            return 2;
        if (node_reg > MAX_NODES)
            return MAX_NODES;
        return int'(node_reg);
    endfunction

    function automatic void sweep_distances(input int src, input int n,
                                            output longint dist_arr [MAX_NODES]);
        bit done [MAX_NODES];
        int best;
        int a;
        int b;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            dist_arr[i] = FAR;
            done[i] = 0;
        end
        dist_arr[src] = 0;
        for (int r = 0; r < n; r++)
        begin
            best = n;
            for (int i = 0; i < n; i++)
                if (!done[i] && dist_arr[i] != FAR &&
                    (best == n || dist_arr[i] < dist_arr[best]))
                    best = i;
            if (best == n)
                break;
            done[best] = 1;
            for (int k = 0; k < edge_count; k++)
            begin
                a = edge_a[k];
                b = edge_b[k];
                if (a >= n || b >= n)
                    continue;
                if (a == best && dist_arr[best] + edge_w[k] < dist_arr[b])
                    dist_arr[b] = dist_arr[best] + edge_w[k];
                if (b == best && dist_arr[best] + edge_w[k] < dist_arr[a])
                    dist_arr[a] = dist_arr[best] + edge_w[k];
            end
        end
    endfunction

    function automatic bit edge_on_route(input int k, input int n);
        longint total;
        int u;
        int v;
        total = from_start[n - 1];
        u = edge_a[k];
        v = edge_b[k];
        if (total == FAR || u >= n || v >= n)
            return 0;
        if (from_start[u] != FAR && from_end[v] != FAR &&
            from_start[u] + edge_w[k] + from_end[v] == total)
            return 1;
        if (from_start[v] != FAR && from_end[u] != FAR &&
            from_start[v] + edge_w[k] + from_end[u] == total)
            return 1;
        return 0;
    endfunction

    function automatic bit predict_word(input kind_t kind, input logic [7:0] a,
                                        input logic [7:0] b, input logic [15:0] w,
                                        input logic [9:0] idx, output answer_t ans);
        int n;
        ans = '{idx: idx, onp: 1'b0, bad: 1'b0};
        case (kind)
            KIND_LOAD:
            begin
                if (edge_count < MAX_EDGES)
                begin
                    edge_a[edge_count] = a;
                    edge_b[edge_count] = b;
                    edge_w[edge_count] = w;
                    edge_count++;
                end
                dist_valid = 0;
                return 0;
            end
            KIND_CLEAR:
            begin
                edge_count = 0;
                dist_valid = 0;
                return 0;
            end
            KIND_QUERY:
            begin
                n = active_nodes();
                if (!dist_valid)
                begin
                    sweep_distances(0, n, from_start);
                    sweep_distances(n - 1, n, from_end);
                    dist_valid = 1;
                end
                if (idx >= edge_count)
                    ans.bad = 1'b1;
                else
                    ans.onp = edge_on_route(idx, n);
                return 1;
            end
            default:
                return 0;
        endcase
    endfunction

    task automatic send_word(input kind_t kind, input int a, input int b,
                             input int w, input int idx,
                             input bit typed = 0, input bit onp = 0, input bit bad = 0);
        answer_t ans;
        int gap;
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= kind;
        in_ch.node_a     <= 8'(a);
        in_ch.node_b     <= 8'(b);
        in_ch.weight     <= 16'(w);
        in_ch.edge_index <= 10'(idx);
        do
            @(posedge clk);
        while (!in_ch.ready);
        words_sent++;
        if (predict_word(kind, 8'(a), 8'(b), 16'(w), 10'(idx), ans))
        begin
            if (typed)
            begin
                ans.onp = onp;
                ans.bad = bad;
            end
            answer_q.push_back(ans);
        end
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 8);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (16)
            @(posedge clk);
    endtask

    task automatic write_nodes(input int value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= 9'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        node_reg   = 9'(value);
        dist_valid = 0;
    endtask

    // receiver: stall pattern that changes mode, with an optional long hold
    initial
    begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(16, 200);
            end
            left--;
            if (hold_req > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_req--;
            end
            else
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= ($urandom_range(0, 1) == 0);
                    2: out_ch.ready <= ($urandom_range(0, 7) != 0);
                    default: out_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
        end
    end

    always @(posedge clk)
    begin
        answer_t exp_ans;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (answer_q.size() == 0)
            begin
                $display("%0t: unexpected answer idx=%0d onp=%0b bad=%0b", $time,
                         out_ch.answer_index, out_ch.on_shortest_path, out_ch.bad_index);
                errors++;
            end
            else
            begin
                exp_ans = answer_q.pop_front();
                if (out_ch.answer_index !== exp_ans.idx)
                begin
                    $display("%0t: answer_index expected %0d actual %0d", $time,
                             exp_ans.idx, out_ch.answer_index);
                    errors++;
                end
                if (out_ch.on_shortest_path !== exp_ans.onp)
                begin
                    $display("%0t: on_shortest_path idx %0d expected %0b actual %0b", $time,
                             exp_ans.idx, exp_ans.onp, out_ch.on_shortest_path);
                    errors++;
                end
                if (out_ch.bad_index !== exp_ans.bad)
                begin
                    $display("%0t: bad_index idx %0d expected %0b actual %0b", $time,
                             exp_ans.idx, exp_ans.bad, out_ch.bad_index);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #40000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic row_t wrow(input kind_t kind, input int a, input int b, input int w,
                                  input int idx, input bit typed = 0, input bit onp = 0,
                                  input bit bad = 0);
        return '{op: ROW_WORD, kind: kind, a: a, b: b, w: w, idx: idx,
                 typed: typed, onp: onp, bad: bad};
    endfunction

    function automatic row_t crow(input int value);
        return '{op: ROW_CFG, kind: KIND_NONE, a: 0, b: 0, w: 0, idx: value,
                 typed: 0, onp: 0, bad: 0};
    endfunction

    initial
    begin
        row_t rows[$];
        int n;
        int n_edges;
        int n_queries;
        int wmax;
        int hi;
        bit big;
        int a;
        int b;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        in_ch.valid   = 1'b0;
        in_ch.kind    = KIND_NONE;
        in_ch.node_a  = '0;
        in_ch.node_b  = '0;
        in_ch.weight  = '0;
        in_ch.edge_index = '0;
        edge_count    = 0;
        dist_valid    = 0;
        node_reg      = 9'd2;
        errors        = 0;
        burst_left    = 0;
        hold_req      = 0;
        words_sent    = 0;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            from_start[i] = FAR;
            from_end[i]   = FAR;
        end
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back(wrow(KIND_QUERY, 0, 0, 0, 0, 1, 0, 1));
        rows.push_back(wrow(KIND_LOAD, 0, 1, 1, 0));
        rows.push_back(wrow(KIND_QUERY, 0, 0, 0, 0, 1, 1, 0));
        rows.push_back(wrow(KIND_LOAD, 0, 1, 65535, 0));
        rows.push_back(wrow(KIND_QUERY, 0, 0, 0, 1, 1, 0, 0));
        rows.push_back(wrow(KIND_LOAD, 1, 0, 0, 0));
        rows.push_back(wrow(KIND_QUERY, 0, 0, 0, 2, 1, 1, 0));
        rows.push_back(wrow(KIND_QUERY, 0, 0, 0, 0));
        rows.push_back(wrow(KIND_LOAD, 0, 255, 7, 0));
        rows.push_back(wrow(KIND_QUERY, 0, 0, 0, 3, 1, 0, 0));
        rows.push_back(wrow(KIND_NONE, 255, 255, 65535, 1023));
        rows.push_back(wrow(KIND_QUERY, 0, 0, 0, 1023, 1, 0, 1));
        rows.push_back(wrow(KIND_CLEAR, 0, 0, 0, 0));
        rows.push_back(wrow(KIND_QUERY, 0, 0, 0, 0, 1, 0, 1));
        rows.push_back(wrow(KIND_LOAD, 0, 0, 5, 0));
        rows.push_back(wrow(KIND_QUERY, 0, 0, 0, 0, 1, 0, 0));
        rows.push_back(crow(5));
        rows.push_back(wrow(KIND_LOAD, 0, 1, 3, 0));
        rows.push_back(wrow(KIND_QUERY, 0, 0, 0, 1, 1, 0, 0));
        rows.push_back(crow(0));
        rows.push_back(wrow(KIND_QUERY, 0, 0, 0, 1));
        rows.push_back(crow(1));
        rows.push_back(wrow(KIND_QUERY, 0, 0, 0, 1));
        rows.push_back(crow(511));
        rows.push_back(wrow(KIND_LOAD, 0, 255, 9, 0));
        rows.push_back(wrow(KIND_QUERY, 0, 0, 0, 2));
        rows.push_back(crow(256));
        rows.push_back(wrow(KIND_QUERY, 0, 0, 0, 2));

        foreach (rows[i])
        begin
            if (rows[i].op == ROW_CFG)
                write_nodes(rows[i].idx);
            else
                send_word(rows[i].kind, rows[i].a, rows[i].b, rows[i].w, rows[i].idx,
                          rows[i].typed, rows[i].onp, rows[i].bad);
        end

        // fill the edge list past capacity on a small graph
        write_nodes(4);
        send_word(KIND_CLEAR, 0, 0, 0, 0);
        for (int k = 0; k < MAX_EDGES + 2; k++)
            send_word(KIND_LOAD, $urandom_range(0, 4), $urandom_range(0, 4),
                      $urandom_range(1, 65535), 0);
        send_word(KIND_QUERY, 0, 0, 0, 1023);
        send_word(KIND_QUERY, 0, 0, 0, 0);
        for (int k = 0; k < 10; k++)
            send_word(KIND_QUERY, 0, 0, 0, $urandom_range(0, 1023));

        // long hold on the result side while queries keep coming
        send_word(KIND_CLEAR, 0, 0, 0, 0);
        drain();
        for (int k = 0; k < 6; k++)
            send_word(KIND_LOAD, k % 4, (k + 1) % 4, $urandom_range(1, 4), 0);
        send_word(KIND_QUERY, 0, 0, 0, 0);
        drain();
        hold_req = 400;
        for (int k = 0; k < 40; k++)
            send_word(KIND_QUERY, 0, 0, 0, $urandom_range(0, 7));
        drain();

        while (words_sent < 1200)
        begin
            big = ($urandom_range(0, 99) < 3);
            if ($urandom_range(0, 3) != 0 || big)
            begin
                if (big)
                    n = ($urandom_range(0, 1) == 0) ? 256 : $urandom_range(200, 511);
                else
                    n = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1)
                                                  : $urandom_range(2, 12);
                write_nodes(n);
            end
            n = active_nodes();
            if ($urandom_range(0, 4) != 0 || edge_count > 60 || big)
                send_word(KIND_CLEAR, 0, 0, 0, 0);
            n_edges = big ? $urandom_range(4, 20) : $urandom_range(1, 3 * n + 2);
            wmax = $urandom_range(0, 2) == 0 ? 65535 : $urandom_range(1, 4);
            for (int k = 0; k < n_edges; k++)
            begin
                if (big && k == 0)
                begin
                    a = 0;
                    b = n - 1;
                end
                else
                begin
                    a = $urandom_range(0, 19) == 0 ? $urandom_range(0, 255)
                                                   : $urandom_range(0, n - 1);
                    b = $urandom_range(0, 19) == 0 ? $urandom_range(0, 255)
                                                   : $urandom_range(0, n - 1);
                end
                send_word(KIND_LOAD, a, b,
                          $urandom_range(0, 15) == 0 ? 0 : $urandom_range(1, wmax), 0);
            end
            n_queries = $urandom_range(2, 12);
            for (int k = 0; k < n_queries; k++)
            begin
                hi = edge_count > 0 ? edge_count - 1 : 0;
                case ($urandom_range(0, 19))
                    0: send_word(KIND_NONE, $urandom_range(0, 255), $urandom_range(0, 255),
                                 $urandom_range(0, 65535), $urandom_range(0, 1023));
                    1: if (!big)
                           send_word(KIND_LOAD, $urandom_range(0, n - 1),
                                     $urandom_range(0, n - 1), $urandom_range(1, wmax), 0);
                    2: send_word(KIND_QUERY, 0, 0, 0, $urandom_range(0, 1023));
                    default: send_word(KIND_QUERY, $urandom_range(0, 255),
                                       $urandom_range(0, 255), $urandom_range(0, 65535),
                                       $urandom_range(0, hi));
                endcase
            end
            if ($urandom_range(0, 9) == 0)
                drain();
        end

        drain();
        repeat (64)
            @(posedge clk);
        if (errors == 0 && answer_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
